@@ rtl/esp_pkg.sv @@
// ----------------------------------------------------------------------------
// esp_pkg
// Shared widths, register codes and types of the encoder speed estimator.
// ----------------------------------------------------------------------------
package esp_pkg;

    // WINDOW_SIZE must be a power of two
    localparam int COUNTER_BITS = 16;
    localparam int WINDOW_SIZE  = 8;
    localparam int WIN_LOG2     = $clog2(WINDOW_SIZE);
    localparam int PHASE_W      = WIN_LOG2;
    localparam int DELTA_W      = COUNTER_BITS + 1;
    localparam int SUM_W        = COUNTER_BITS + WIN_LOG2 + 1;
    localparam int AVG_W        = SUM_W - WIN_LOG2;
    localparam int POS_W        = 32;
    localparam int SPEED_W      = 16;
    localparam int GAIN_W       = 16;
    localparam int GAIN_FRAC    = 8;
    localparam int LIMIT_W      = 15;
    localparam int PROD_W       = AVG_W + GAIN_W + 1;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(WINDOW_SIZE - 1);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(192);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3000);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [LIMIT_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      reverse;
    } t_speed_res;

endpackage

@@ rtl/esp_delta.sv @@
// ----------------------------------------------------------------------------
// esp_delta
// Wrap-corrected difference between two counter readings.
// ----------------------------------------------------------------------------
module esp_delta (
    input  logic [esp_pkg::COUNTER_BITS-1:0] i_cur,
    input  logic [esp_pkg::COUNTER_BITS-1:0] i_prev,
    output logic signed [esp_pkg::DELTA_W-1:0] o_delta
);
    import esp_pkg::*;

    localparam int RAW_W = COUNTER_BITS + 2;
    localparam logic signed [RAW_W-1:0] HALF = RAW_W'(1) <<< (COUNTER_BITS - 1);
    localparam logic signed [RAW_W-1:0] FULL = RAW_W'(1) <<< COUNTER_BITS;

    logic signed [RAW_W-1:0] s_raw;
    logic signed [RAW_W-1:0] s_fix;

    always_comb begin
        s_raw = $signed({2'b00, i_cur}) - $signed({2'b00, i_prev});
        if (s_raw > HALF) begin
            s_fix = s_raw - FULL;
        end else if (s_raw < -HALF) begin
            s_fix = s_raw + FULL;
        end else begin
            s_fix = s_raw;
        end
    end

    assign o_delta = s_fix[DELTA_W-1:0];

endmodule

@@ rtl/esp_speed.sv @@
// ----------------------------------------------------------------------------
// esp_speed
// Window average, Q8.8 gain scaling and symmetric clamp of the speed.
// ----------------------------------------------------------------------------
module esp_speed (
    input  logic signed [esp_pkg::SUM_W-1:0] i_sum,
    input  esp_pkg::t_cfg                    i_cfg,
    output esp_pkg::t_speed_res              o_res
);
    import esp_pkg::*;

    logic signed [SUM_W-1:0]  s_bias;
    logic signed [SUM_W-1:0]  s_avg_full;
    logic signed [AVG_W-1:0]  s_avg;
    logic signed [PROD_W-1:0] s_prod;
    logic signed [PROD_W-1:0] s_pbias;
    logic signed [PROD_W-1:0] s_rpm;
    logic signed [PROD_W-1:0] s_lim_pos;
    logic signed [PROD_W-1:0] s_lim_neg;
    logic signed [PROD_W-1:0] s_clamp;

    always_comb begin
        // truncate toward zero
        s_bias     = i_sum[SUM_W-1] ? SUM_W'(WINDOW_SIZE - 1) : '0;
        s_avg_full = (i_sum + s_bias) >>> WIN_LOG2;
        s_avg      = s_avg_full[AVG_W-1:0];
        s_prod     = s_avg * $signed({1'b0, i_cfg.gain});
        s_pbias    = s_prod[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC) - 1) : '0;
        s_rpm      = (s_prod + s_pbias) >>> GAIN_FRAC;
        s_lim_pos  = $signed({{(PROD_W-LIMIT_W){1'b0}}, i_cfg.limit});
        s_lim_neg  = -s_lim_pos;
        if (s_rpm > s_lim_pos) begin
            s_clamp = s_lim_pos;
        end else if (s_rpm < s_lim_neg) begin
            s_clamp = s_lim_neg;
        end else begin
            s_clamp = s_rpm;
        end
        o_res.speed   = s_clamp[SPEED_W-1:0];
        o_res.reverse = s_avg[AVG_W-1];
    end

endmodule

@@ rtl/encoder_speed_estimator.sv @@
// ----------------------------------------------------------------------------
// encoder_speed_estimator
// M-method speed estimate from a free-running quadrature counter.
//
// Input channel (i_in_valid / o_in_stall) carries one transaction per sample
// tick: kind selects a counter sample or a clear of position and speed.
// Output channel (o_out_valid / i_out_stall) returns exactly one transaction
// per input transaction, in order: position, speed, reverse, speed_updated.
// Each transaction passes the input register, then the result register;
// throughput is one transaction per cycle while the receiver does not stall,
// set by the update of the position and window sum registers between stages.
// Gain and limit are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must do so while the block is idle; the block does not enforce it.
// Reset, which is synchronous, loads gain 0.75 (Q8.8) and limit 3000, empties
// both stages and clears the estimator state. When the receiver stalls, the
// result register holds; a new transaction is still taken while the input
// register is empty, and o_in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module encoder_speed_estimator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [esp_pkg::COUNTER_BITS-1:0]  i_counter_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [esp_pkg::POS_W-1:0]  o_position,
    output logic signed [esp_pkg::SPEED_W-1:0] o_speed,
    output logic                              o_reverse,
    output logic                              o_speed_updated,
    input  logic                              i_cfg_we,
    input  logic [esp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [esp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import esp_pkg::*;

    t_cfg                     r_cfg;
    logic                     r_in_vld;
    logic                     r_in_kind;
    logic [COUNTER_BITS-1:0]  r_in_count;
    logic                     r_out_vld;
    logic signed [POS_W-1:0]  r_out_pos;
    t_speed_res               r_out_res;
    logic                     r_out_upd;

    logic [COUNTER_BITS-1:0]  r_prev;
    logic signed [POS_W-1:0]  r_pos;
    logic signed [SUM_W-1:0]  r_sum;
    logic [PHASE_W-1:0]       r_phase;
    t_speed_res               r_res;

    logic [COUNTER_BITS-1:0]  n_prev;
    logic signed [POS_W-1:0]  n_pos;
    logic signed [SUM_W-1:0]  n_sum;
    logic [PHASE_W-1:0]       n_phase;
    t_speed_res               n_res;
    logic                     n_upd;

    logic                     s_out_free;
    logic                     s_adv;
    logic signed [DELTA_W-1:0] s_delta;
    logic signed [SUM_W-1:0]  s_sum_acc;
    t_speed_res               s_new_res;

    assign s_out_free = !r_out_vld || !i_out_stall;
    assign s_adv      = r_in_vld && s_out_free;
    assign o_in_stall = r_in_vld && !s_out_free;

    esp_delta u_delta (
        .i_cur   (r_in_count),
        .i_prev  (r_prev),
        .o_delta (s_delta)
    );

    assign s_sum_acc = r_sum + SUM_W'(s_delta);

    esp_speed u_speed (
        .i_sum (s_sum_acc),
        .i_cfg (r_cfg),
        .o_res (s_new_res)
    );

    always_comb begin
        n_prev  = r_in_count;
        n_pos   = r_pos + POS_W'(s_delta);
        n_sum   = s_sum_acc;
        n_phase = r_phase + PHASE_W'(1);
        n_res   = r_res;
        n_upd   = 1'b0;
        if (r_in_kind == KIND_CLEAR) begin
            n_prev  = '0;
            n_pos   = '0;
            n_sum   = '0;
            n_phase = r_phase;
            n_res   = '0;
        end else if (r_phase == PHASE_LAST) begin
            n_sum   = '0;
            n_phase = '0;
            n_res   = s_new_res;
            n_upd   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain  <= GAIN_RESET;
            r_cfg.limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN:  r_cfg.gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT: r_cfg.limit <= i_cfg_data[LIMIT_W-1:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_kind  <= i_kind;
            r_in_count <= i_counter_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_phase <= '0;
            r_res   <= '0;
        end else if (s_adv) begin
            r_prev  <= n_prev;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_phase <= n_phase;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out_pos <= n_pos;
            r_out_res <= n_res;
            r_out_upd <= n_upd;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_position      = r_out_pos;
    assign o_speed         = r_out_res.speed;
    assign o_reverse       = r_out_res.reverse;
    assign o_speed_updated = r_out_upd;

endmodule

@@ rtl/esp_checker.sv @@
// ----------------------------------------------------------------------------
// esp_checker
// Port-level checks of the encoder speed estimator, bound to the top level.
// ----------------------------------------------------------------------------
module esp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [esp_pkg::POS_W-1:0]  o_position,
    input  logic signed [esp_pkg::SPEED_W-1:0] o_speed,
    input  logic                              o_reverse,
    input  logic                              o_speed_updated
);
    import esp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_position)
            && $stable(o_speed) && $stable(o_reverse) && $stable(o_speed_updated))
        else $error("stalled result transaction changed");

    a_rev_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reverse |-> o_speed <= 0)
        else $error("reverse flag with positive speed");

    a_fwd_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reverse |-> o_speed >= 0)
        else $error("forward flag with negative speed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind encoder_speed_estimator esp_checker u_esp_checker (.*);

@@ test/encoder_speed_estimator_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_speed_estimator_check
// Watches the sample, result and register ports of the speed estimator. Keeps
// its own copy of the count, position, window and gain state, works out the
// expected result of every accepted sample or clear, and compares each
// returned result field by field, in order. Counts failures for the top.
// ----------------------------------------------------------------------------
module encoder_speed_estimator_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_kind,
    input  logic [esp_pkg::COUNTER_BITS-1:0]    i_counter_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [esp_pkg::POS_W-1:0]    i_position,
    input  logic signed [esp_pkg::SPEED_W-1:0]  i_speed,
    input  logic                                i_reverse,
    input  logic                                i_speed_updated,
    input  logic                                i_cfg_we,
    input  logic [esp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [esp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import esp_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0]   position;
        logic signed [SPEED_W-1:0] speed;
        logic                      reverse;
        logic                      speed_updated;
    } t_speed_report;

    t_speed_report             expected_reports[$];
    logic [GAIN_W-1:0]         gain_q8;
    logic [LIMIT_W-1:0]        speed_limit;
    logic [COUNTER_BITS-1:0]   prev_reading;
    logic [POS_W-1:0]          position_acc;
    int                        window_acc;
    int                        window_count;
    logic signed [SPEED_W-1:0] held_speed;
    logic                      held_reverse;

    function automatic t_speed_report estimate_speed(
        input logic                    kind,
        input logic [COUNTER_BITS-1:0] count
    );
        t_speed_report rep;
        int            delta;
        int            avg;
        longint        rpm;
        longint        lim;
        rep.speed_updated = 1'b0;
        if (kind == KIND_CLEAR) begin
            prev_reading = '0;
            position_acc = '0;
            window_acc   = 0;
            held_speed   = '0;
            held_reverse = 1'b0;
        end else begin
            delta = int'(count) - int'(prev_reading);
            if (delta > (1 << (COUNTER_BITS - 1)))
                delta -= (1 << COUNTER_BITS);
            if (delta < -(1 << (COUNTER_BITS - 1)))
                delta += (1 << COUNTER_BITS);
            prev_reading = count;
            position_acc = position_acc + POS_W'(delta);
            window_acc   += delta;
            window_count++;
            if (window_count >= WINDOW_SIZE) begin
                window_count = 0;
                avg          = window_acc / WINDOW_SIZE;
                window_acc   = 0;
                rpm = (longint'(avg) * longint'(gain_q8)) / (longint'(1) << GAIN_FRAC);
                lim = longint'(speed_limit);
                if (rpm > lim)
                    rpm = lim;
                if (rpm < -lim)
                    rpm = -lim;
                held_speed        = SPEED_W'(rpm);
                held_reverse      = (avg < 0);
                rep.speed_updated = 1'b1;
            end
        end
        rep.position = position_acc;
        rep.speed    = held_speed;
        rep.reverse  = held_reverse;
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        t_speed_report want;
        if (!i_rst_n) begin
            gain_q8      = GAIN_RESET;
            speed_limit  = LIMIT_RESET;
            prev_reading = '0;
            position_acc = '0;
            window_acc   = 0;
            window_count = 0;
            held_speed   = '0;
            held_reverse = 1'b0;
            expected_reports.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN:  gain_q8     = i_cfg_data[GAIN_W-1:0];
                    CFG_LIMIT: speed_limit = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_reports.push_back(estimate_speed(i_kind, i_counter_value));
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result transaction, position %0d speed %0d",
                             $time, i_position, i_speed);
                    o_fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_position !== want.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, i_position);
                        o_fail_count++;
                    end
                    if (i_speed !== want.speed) begin
                        $display("%0t: speed expected %0d actual %0d",
                                 $time, want.speed, i_speed);
                        o_fail_count++;
                    end
                    if (i_reverse !== want.reverse) begin
                        $display("%0t: reverse expected %0b actual %0b",
                                 $time, want.reverse, i_reverse);
                        o_fail_count++;
                    end
                    if (i_speed_updated !== want.speed_updated) begin
                        $display("%0t: speed_updated expected %0b actual %0b",
                                 $time, want.speed_updated, i_speed_updated);
                        o_fail_count++;
                    end
                end
            end
            o_pending = expected_reports.size();
        end
    end

endmodule

@@ test/encoder_speed_estimator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_speed_estimator_test
// Drives the speed estimator with directed wrap, clear and clamp cases, then
// with simulated encoder motion at several speeds plus noise and clears,
// under several gain and limit settings. Both channels idle at random. The
// checker beside the block predicts and compares; this module gives verdict.
// ----------------------------------------------------------------------------
module encoder_speed_estimator_test;
    import esp_pkg::*;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      kind          = KIND_SAMPLE;
    logic [COUNTER_BITS-1:0]   counter_value = '0;
    logic                      out_stall     = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index     = CFG_GAIN;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;
    logic                      in_stall;
    logic                      out_valid;
    logic signed [POS_W-1:0]   position;
    logic signed [SPEED_W-1:0] speed;
    logic                      reverse;
    logic                      speed_updated;
    int                        fail_count;
    int                        pending;
    logic                      idling_on     = 1'b1;
    logic [COUNTER_BITS-1:0]   encoder_count = '0;
    int                        rate          = 0;

    encoder_speed_estimator u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (kind),
        .i_counter_value (counter_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_position      (position),
        .o_speed         (speed),
        .o_reverse       (reverse),
        .o_speed_updated (speed_updated),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    encoder_speed_estimator_check u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_kind          (kind),
        .i_counter_value (counter_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_position      (position),
        .i_speed         (speed),
        .i_reverse       (reverse),
        .i_speed_updated (speed_updated),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= idling_on && ($urandom_range(0, 99) < 13);
    end

    task automatic send_item(input logic item_kind, input logic [COUNTER_BITS-1:0] value);
        logic taken;
        while (idling_on && ($urandom_range(0, 99) < 13)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= item_kind;
        counter_value <= value;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [LIMIT_W-1:0] limit);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAIN;
        cfg_data  <= CFG_DATA_W'(gain);
        @(posedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_data  <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic sample_at(input logic [COUNTER_BITS-1:0] value);
        encoder_count = value;
        send_item(KIND_SAMPLE, value);
    endtask

    task automatic directed_items();
        sample_at(16'd0);
        sample_at(16'd32768);
        sample_at(16'd0);
        sample_at(16'd32769);
        sample_at(16'd0);
        sample_at(16'd65535);
        sample_at(16'd0);
        sample_at(16'd1000);
        send_item(KIND_CLEAR, 16'hFFFF);
        encoder_count = '0;
        sample_at(16'd65535);
        sample_at(16'd65535);
        sample_at(16'd65534);
        sample_at(16'd65534);
        sample_at(16'd65534);
        sample_at(16'd65534);
        sample_at(16'd65534);
        sample_at(16'd65533);
        repeat (7)
            sample_at(encoder_count + 16'd30000);
        send_item(KIND_CLEAR, 16'h0000);
        encoder_count = '0;
        sample_at(16'd40);
    endtask

    task automatic run_motion(input int count);
        int r;
        int jitter;
        for (int i = 0; i < count; i++) begin
            if (i % 16 == 0) begin
                case ($urandom_range(0, 3))
                    0: rate = int'($urandom_range(0, 100)) - 50;
                    1: rate = int'($urandom_range(0, 4000)) - 2000;
                    2: rate = int'($urandom_range(0, 65536)) - 32768;
                    default: rate = $urandom_range(0, 1) ? 32768 : -32768;
                endcase
            end
            r      = $urandom_range(0, 99);
            jitter = (r < 50) ? int'($urandom_range(0, 6)) - 3 : 0;
            if (r < 3) begin
                send_item(KIND_CLEAR, COUNTER_BITS'($urandom));
                encoder_count = '0;
            end else if (r < 10) begin
                sample_at(COUNTER_BITS'($urandom));
            end else begin
                sample_at(encoder_count + COUNTER_BITS'(rate + jitter));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        set_config(16'd192, 15'd3000);
        run_motion(150);
        set_config(16'hFFFF, 15'h7FFF);
        run_motion(150);
        set_config(16'd0, 15'd100);
        run_motion(100);
        set_config(16'd256, 15'd0);
        run_motion(100);
        set_config(GAIN_W'($urandom), LIMIT_W'($urandom));
        idling_on = 1'b0;
        run_motion(250);
        idling_on = 1'b1;
        set_config(16'd1, 15'h7FFF);
        run_motion(150);
        set_config(GAIN_W'($urandom), 15'd1);
        run_motion(150);
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ encoder_speed_estimator.f @@
rtl/esp_pkg.sv
rtl/esp_delta.sv
rtl/esp_speed.sv
rtl/encoder_speed_estimator.sv
rtl/esp_checker.sv
test/encoder_speed_estimator_check.sv
test/encoder_speed_estimator_test.sv
